// File: rtl/core/pllds_pkg.sv
// ----------------------------------------------------------------------------
// PLL divider/multiplier search package
// Shared types, register indexes and reset values.
// ----------------------------------------------------------------------------
package pllds_pkg;

  localparam int unsigned RateW = 32;
  localparam int unsigned DivW  = 6;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CfgVcoMax  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgVcoMin  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMultMin = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMultMax = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDivMax  = 3'd4;

  localparam logic [RateW-1:0] VcoMaxRst  = 32'd600000000;
  localparam logic [RateW-1:0] VcoMinRst  = 32'd300000000;
  localparam logic [DivW-1:0]  MultMinRst = 6'd4;
  localparam logic [DivW-1:0]  MultMaxRst = 6'd32;
  localparam logic [DivW-1:0]  DivMaxRst  = 6'd3;

  typedef struct packed {
    logic [RateW-1:0] target_rate;
    logic [RateW-1:0] reference_rate;
  } req_t;

  typedef struct packed {
    logic [RateW-1:0] achieved_rate;
    logic [DivW-1:0]  pre_divider;
    logic [DivW-1:0]  multiplier;
    logic [DivW-1:0]  post_divider;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POST,    // start a post divider
    ST_CAPDIV,  // vco_max / d2, bit serial
    ST_PRE,     // start a pre divider
    ST_QDIV,    // ref / d1, bit serial
    ST_STDIV,   // cap / q, bit serial
    ST_MULT,    // q * m, bit serial
    ST_RDIV,    // vco / d2, bit serial
    ST_EVAL,
    ST_DONE
  } state_e;

endpackage

// File: rtl/core/pll_divider_multiplier_search_unit.sv
// ----------------------------------------------------------------------------
// PLL divider/multiplier search unit
// Searches post, pre divider and multiplier for the best rate at or below target.
// ----------------------------------------------------------------------------
// One word is accepted when start_i is high and busy_o is low; busy_o stays
// high until the result, shown for one cycle with done_o, which the receiver
// must take. Divisions and the q * m product are bit serial over one shared
// shift-subtract / shift-add datapath, one bit per cycle; the cap target*d2 is
// a parallel multiply. Each post divider runs a vco_max / d2 division, each
// divider pair two divisions (ref / d1 and cap / q), and each multiplier tried
// a multiply and a division by d2.
module pll_divider_multiplier_search_unit
  import pllds_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  req_t               req_i,
  output logic               busy_o,
  output logic               done_o,
  output rsp_t               rsp_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [RateW-1:0]   cfg_data_i
);

  localparam int unsigned WW = RateW + DivW; // wide for products
  localparam int unsigned CntW = $clog2(WW + 1);

  state_e state_q, state_d;

  logic [RateW-1:0] vco_max_q, vco_min_q;
  logic [DivW-1:0]  mult_min_q, mult_max_q, div_max_q;

  logic [RateW-1:0] target_q, ref_q;
  logic [DivW:0]    d1_q, d2_q;   // one extra bit to step past div_max
  logic [DivW:0]    m_q;       // may step to below mult_min with one extra bit
  logic [RateW-1:0] q_q;
  logic [WW-1:0]    cap_q;
  logic [RateW-1:0] best_rate_q;
  logic [DivW-1:0]  best_pre_q, best_mult_q, best_post_q;

  // serial unit
  logic [WW-1:0]    num_q;     // dividend shift / multiplier bits
  logic [WW-1:0]    quo_q;
  logic [WW:0]      rem_q;
  logic [WW-1:0]    den_q;
  logic [CntW-1:0]  cnt_q;

  logic [WW:0]      rem_sh, rem_sub;
  logic             rem_ge;

  assign rem_sh  = {rem_q[WW-1:0], num_q[WW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign rem_ge  = !rem_sub[WW];
  wire [WW-1:0] quo_nx = {quo_q[WW-2:0], rem_ge};
  wire          ser_last = (cnt_q == CntW'(1));

  wire [WW-1:0] t_wide  = {{DivW{1'b0}}, target_q};
  wire [WW-1:0] rate_w  = quo_nx;

  // ------------------------------------------------------------ config
  assign cfg_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vco_max_q  <= VcoMaxRst;
      vco_min_q  <= VcoMinRst;
      mult_min_q <= MultMinRst;
      mult_max_q <= MultMaxRst;
      div_max_q  <= DivMaxRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgVcoMax:  vco_max_q  <= cfg_data_i;
        CfgVcoMin:  vco_min_q  <= cfg_data_i;
        CfgMultMin: mult_min_q <= cfg_data_i[DivW-1:0];
        CfgMultMax: mult_max_q <= cfg_data_i[DivW-1:0];
        CfgDivMax:  div_max_q  <= cfg_data_i[DivW-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (start_i) state_d = ST_POST;
      ST_POST:   state_d = (d2_q > {1'b0, div_max_q}) ? ST_DONE : ST_CAPDIV;
      ST_CAPDIV: if (ser_last) state_d = ST_PRE;
      ST_PRE:    state_d = (d1_q > {1'b0, div_max_q}) ? ST_POST : ST_QDIV;
      ST_QDIV:   if (ser_last) state_d = (quo_nx == '0) ? ST_PRE : ST_STDIV;
      ST_STDIV:  if (ser_last) state_d = ST_EVAL;
      ST_EVAL:   state_d = (m_q < {1'b0, mult_min_q} || m_q[DivW]) ? ST_PRE : ST_MULT;
      ST_MULT:   if (ser_last)
                   state_d = ((rem_q[WW-1:0] + (num_q[0] ? den_q : '0))
                              < {{DivW{1'b0}}, vco_min_q}) ? ST_PRE : ST_RDIV;
      ST_RDIV:   if (ser_last) begin
                   if (rate_w > t_wide) state_d = ST_EVAL;
                   else if (rate_w[RateW-1:0] < best_rate_q) state_d = ST_PRE;
                   else state_d = ST_EVAL;
                 end
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // ------------------------------------------------------------ datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: if (start_i) begin
        target_q    <= req_i.target_rate;
        ref_q       <= req_i.reference_rate;
        d2_q        <= (DivW+1)'(1);
        best_rate_q <= '0;
        best_pre_q  <= '0;
        best_mult_q <= '0;
        best_post_q <= '0;
      end
      ST_POST: begin
        // vco_max / d2
        num_q <= {{DivW{1'b0}}, vco_max_q};
        den_q <= {{(RateW-1){1'b0}}, d2_q};
        rem_q <= '0;
        quo_q <= '0;
        cnt_q <= CntW'(WW);
        d1_q  <= (DivW+1)'(1);
      end
      ST_CAPDIV: begin
        rem_q <= rem_ge ? rem_sub : rem_sh;
        quo_q <= quo_nx;
        num_q <= num_q << 1;
        cnt_q <= cnt_q - 1'b1;
        if (ser_last) begin
          // target > vco_max/d2 -> cap = vco_max, else target*d2 (fits)
          if (t_wide > quo_nx) cap_q <= {{DivW{1'b0}}, vco_max_q};
          else                 cap_q <= WW'(target_q * d2_q);
        end
      end
      ST_PRE: begin
        num_q <= {{DivW{1'b0}}, ref_q};
        den_q <= {{(RateW-1){1'b0}}, d1_q};
        rem_q <= '0;
        quo_q <= '0;
        cnt_q <= CntW'(WW);
      end
      ST_QDIV, ST_STDIV, ST_RDIV: begin
        rem_q <= rem_ge ? rem_sub : rem_sh;
        quo_q <= quo_nx;
        num_q <= num_q << 1;
        cnt_q <= cnt_q - 1'b1;
        if (ser_last && state_q == ST_QDIV) begin
          q_q   <= quo_nx[RateW-1:0];
          d1_q  <= d1_q + 1'b1;
          num_q <= cap_q;
          den_q <= quo_nx;
          rem_q <= '0;
          quo_q <= '0;
          cnt_q <= CntW'(WW);
        end
        if (ser_last && state_q == ST_STDIV)
          m_q <= (quo_nx > {{RateW{1'b0}}, mult_max_q}) ? {1'b0, mult_max_q}
                                                         : (DivW+1)'(quo_nx);
        if (ser_last && state_q == ST_RDIV) begin
          if (rate_w <= t_wide && rate_w[RateW-1:0] >= best_rate_q &&
              (rate_w[RateW-1:0] > best_rate_q || m_q[DivW-1:0] < best_mult_q)) begin
            best_rate_q <= rate_w[RateW-1:0];
            best_pre_q  <= DivW'(d1_q - 1'b1);
            best_mult_q <= m_q[DivW-1:0];
            best_post_q <= d2_q[DivW-1:0];
          end
          m_q <= m_q - 1'b1;
        end
      end
      ST_EVAL: begin
        // multiply q * m, shift-add LSB first: num = m, den = q, rem = acc
        num_q <= {{RateW{1'b0}}, m_q[DivW-1:0]};
        den_q <= {{DivW{1'b0}}, q_q};
        rem_q <= '0;
        cnt_q <= CntW'(DivW);
      end
      ST_MULT: begin
        // acc += m[i] ? q << i : 0
        rem_q <= {1'b0, rem_q[WW-1:0] + (num_q[0] ? den_q : '0)};
        den_q <= den_q << 1;
        num_q <= num_q >> 1;
        cnt_q <= cnt_q - 1'b1;
        if (ser_last) begin
          num_q <= rem_q[WW-1:0] + (num_q[0] ? den_q : '0);
          den_q <= {{(RateW-1){1'b0}}, d2_q};
          rem_q <= '0;
          quo_q <= '0;
          cnt_q <= CntW'(WW);
        end
      end
      ST_DONE: ;
      default: ;
    endcase
    if (state_q == ST_PRE && d1_q > {1'b0, div_max_q}) d2_q <= d2_q + 1'b1;
  end

  // ------------------------------------------------------------ outputs
  always_comb begin
    busy_o = (state_q != ST_IDLE);
    done_o = (state_q == ST_DONE);
    rsp_o.achieved_rate = best_rate_q;
    rsp_o.pre_divider   = best_pre_q;
    rsp_o.multiplier    = best_mult_q;
    rsp_o.post_divider  = best_post_q;
  end

endmodule

// File: rtl/core/pllds_checker.sv
// ----------------------------------------------------------------------------
// PLL search port checker
// Checks the command handshake and result framing seen on the ports.
// ----------------------------------------------------------------------------
module pllds_checker
  import pllds_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input logic cfg_ready_o,
  input rsp_t rsp_o
);

  // accepted word raises busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("start not taken");

  // a result is a single-cycle strobe
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("done while idle");

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !busy_o) else $error("config open while busy");

  // a zero achieved rate (no solution) comes with a zero multiplier
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.achieved_rate == '0) |-> (rsp_o.multiplier == '0))
    else $error("partial empty result");

endmodule

bind pll_divider_multiplier_search_unit pllds_checker u_pllds_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
  .done_o(done_o), .cfg_ready_o(cfg_ready_o), .rsp_o(rsp_o)
);

// File: verif/pll_divider_multiplier_search_unit_tb.sv
// ----------------------------------------------------------------------------
// PLL divider/multiplier search unit testbench
// Drives rate requests and register writes, predicts each search result in
// software and compares every returned word field by field.
// ----------------------------------------------------------------------------
module pll_divider_multiplier_search_unit_tb;
  import pllds_pkg::*;

  class search_scoreboard;
    rsp_t    pending[$];
    int      errors;
    longint unsigned vco_max_r, vco_min_r, mult_min_r, mult_max_r, div_max_r;

    function void reset_regs();
      vco_max_r  = VcoMaxRst;
      vco_min_r  = VcoMinRst;
      mult_min_r = MultMinRst;
      mult_max_r = MultMaxRst;
      div_max_r  = DivMaxRst;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [RateW-1:0] val);
      case (idx)
        CfgVcoMax:  vco_max_r  = val;
        CfgVcoMin:  vco_min_r  = val;
        CfgMultMin: mult_min_r = val[DivW-1:0];
        CfgMultMax: mult_max_r = val[DivW-1:0];
        CfgDivMax:  div_max_r  = val[DivW-1:0];
        default: ;
      endcase
    endfunction

    function rsp_t search(req_t rq);
      rsp_t best;
      longint unsigned tgt, refr, cap, q, st, vco, r, bestr, bestm;
      longint m;
      best  = '0;
      bestr = 0;
      bestm = 0;
      tgt   = rq.target_rate;
      refr  = rq.reference_rate;
      for (longint unsigned d2 = 1; d2 <= div_max_r; d2++) begin
        cap = (tgt > vco_max_r / d2) ? vco_max_r : tgt * d2;
        for (longint unsigned d1 = 1; d1 <= div_max_r; d1++) begin
          q = refr / d1;
          if (q == 0) continue;
          st = cap / q;
          if (st > mult_max_r) st = mult_max_r;
          for (m = longint'(st); m >= longint'(mult_min_r); m--) begin
            vco = q * longint'(m);
            if (vco < vco_min_r) break;
            r = vco / d2;
            if (r > tgt) continue;
            if (r < bestr) break;
            if (r > bestr || longint'(m) < bestm) begin
              bestr = r;
              bestm = m;
              best.achieved_rate = r[RateW-1:0];
              best.pre_divider   = d1[DivW-1:0];
              best.multiplier    = m[DivW-1:0];
              best.post_divider  = d2[DivW-1:0];
            end
          end
        end
      end
      return best;
    endfunction

    function void note_request(req_t rq);
      pending.push_back(search(rq));
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        $error("result word with nothing outstanding: %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.achieved_rate !== want.achieved_rate) begin
        $error("achieved_rate expected %0d actual %0d", want.achieved_rate, got.achieved_rate);
        errors++;
      end
      if (got.pre_divider !== want.pre_divider) begin
        $error("pre_divider expected %0d actual %0d", want.pre_divider, got.pre_divider);
        errors++;
      end
      if (got.multiplier !== want.multiplier) begin
        $error("multiplier expected %0d actual %0d", want.multiplier, got.multiplier);
        errors++;
      end
      if (got.post_divider !== want.post_divider) begin
        $error("post_divider expected %0d actual %0d", want.post_divider, got.post_divider);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  req_t               req_i;
  logic               busy_o;
  logic               done_o;
  rsp_t               rsp_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [RateW-1:0]   cfg_data_i;

  search_scoreboard sb;
  bit               calm;

  pll_divider_multiplier_search_unit dut (.*);

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  initial begin
    #2000000000;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(rsp_o);
  end

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [RateW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_request(logic [RateW-1:0] tgt, logic [RateW-1:0] refr);
    req_t rq;
    rq.target_rate    = tgt;
    rq.reference_rate = refr;
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 12) @(negedge clk_i);
    start_i <= 1'b1;
    req_i   <= rq;
    do @(posedge clk_i); while (busy_o);
    sb.note_request(rq);
    @(negedge clk_i);
    start_i <= 1'b0;
    req_i   <= {$urandom, $urandom};
  endtask

  // hold until every word is back, then let the block settle
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // mostly realistic rates, with noise across the full range
  task automatic random_request();
    logic [RateW-1:0] tgt, refr;
    case ($urandom_range(3))
      0: begin
        tgt  = $urandom;
        refr = $urandom;
      end
      1: begin
        tgt  = $urandom_range(400000000, 1000000);
        refr = $urandom_range(50000000, 1000000);
      end
      default: begin
        refr = $urandom_range(40000000, 10000000);
        tgt  = $urandom_range(300000000, 20000000);
      end
    endcase
    send_request(tgt, refr);
  endtask

  initial begin
    sb = new();
    sb.reset_regs();
    calm        = 1'b0;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgVcoMax;
    cfg_data_i  = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, reset settings
    send_request(32'd100000000, 32'd24000000);
    send_request(32'd0, 32'd24000000);
    send_request(32'hFFFFFFFF, 32'hFFFFFFFF);
    send_request(32'hFFFFFFFF, 32'd1);
    send_request(32'd300000000, 32'd0);
    send_request(32'd1, 32'd2);
    send_request(32'd150000000, 32'd25000000);
    send_request(32'd600000000, 32'd37500000);
    drain();

    // wide product, full register extremes
    write_cfg(CfgVcoMax, 32'hFFFFFFFF);
    write_cfg(CfgVcoMin, 32'd0);
    write_cfg(CfgMultMin, 32'd0);
    write_cfg(CfgMultMax, 32'd32);
    write_cfg(CfgDivMax, 32'd2);
    send_request(32'hFFFFFFFF, 32'hF0000000);
    send_request(32'hC0000000, 32'd3);
    send_request(32'd7, 32'd1);
    send_request(32'd0, 32'd0);
    drain();

    // no pair tried
    write_cfg(CfgDivMax, 32'd0);
    send_request(32'd100000000, 32'd24000000);
    drain();

    // mult_min above mult_max
    write_cfg(CfgDivMax, 32'd4);
    write_cfg(CfgMultMin, 32'd32);
    write_cfg(CfgMultMax, 32'd1);
    send_request(32'd100000000, 32'd24000000);
    write_cfg(CfgMultMax, 32'd32);
    drain();
    write_cfg(CfgMultMin, 32'd1);
    send_request(32'd33, 32'd1);
    send_request(32'd1000, 32'd31);
    drain();

    // random phases across register settings
    for (int ph = 0; ph < 8; ph++) begin
      write_cfg(CfgVcoMax, (ph == 0) ? 32'hFFFFFFFF : $urandom_range(1200000000, 100000000));
      write_cfg(CfgVcoMin, (ph == 1) ? 32'd0 : $urandom_range(300000000, 0));
      write_cfg(CfgMultMin, (ph == 2) ? 32'd63 : $urandom_range(8, 0));
      write_cfg(CfgMultMax, (ph == 3) ? 32'd0 : ((ph == 4) ? 32'd63 : $urandom_range(32, 8)));
      write_cfg(CfgDivMax, (ph == 5) ? 32'd8 : $urandom_range(4, 1));
      calm = (ph == 6);
      for (int k = 0; k < 70; k++) random_request();
      drain();
    end
    calm = 1'b0;

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
